// File: rtl/partitioned_multi_circular_queue_macros.svh
// ----------------------------------------------------------------------------
// Partitioned multi-queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTITIONED_MULTI_CIRCULAR_QUEUE_MACROS_SVH
`define PARTITIONED_MULTI_CIRCULAR_QUEUE_MACROS_SVH

// same-cycle implication
`define PMCQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMCQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pmcq_pkg.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue package
// Types, codes and default sizes shared by the queue modules.
// ----------------------------------------------------------------------------
package pmcq_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int MAX_QUEUES_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int COUNT_W = 4;
  localparam int SEL_W   = 3;
  localparam int WORD_W  = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_SEL = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       operation;
    logic [SEL_W-1:0]          queue_select;
    logic signed [WORD_W-1:0]  data_in;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  data_out;
  } out_item_t;

  typedef struct packed {
    logic    we;
    logic    re;
    status_t status;
  } ctrl_t;

endpackage

// File: rtl/partitioned_multi_circular_queue.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue
// Up to eight circular queues carved from one shared storage array.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer (enqueue or dequeue, queue select, word).
//   out_* : one result per operation, in order: status and dequeued word.
//   cfg_* : writes the queue count; always ready. A write empties every queue
//           and takes effect on the next cycle. Write only while idle.
// The result of a transfer is registered at the transfer edge and is valid
// right after it. Throughput is one operation per cycle unless a result
// stalls; the pointer update and the storage access for an item complete at
// the transfer edge, and the dequeued word is the RAM's registered read data.
// Reset leaves one queue spanning the whole array, empty. Storage is not
// cleared; only words that were enqueued are ever returned.
// While out_valid is high and out_ready is low the result holds and in_ready
// is low, so no operation is taken until the result is transferred.
// ----------------------------------------------------------------------------
`include "partitioned_multi_circular_queue_macros.svh"

module partitioned_multi_circular_queue #(
  parameter int DEPTH      = pmcq_pkg::DEPTH_DEF,
  parameter int MAX_QUEUES = pmcq_pkg::MAX_QUEUES_DEF,
  parameter int DATA_WIDTH = pmcq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pmcq_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pmcq_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pmcq_pkg::COUNT_W-1:0] cfg_data
);
  import pmcq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  ctrl_t                 ctrl;
  logic [PW-1:0]         addr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [63:0]           rdata_ext;
  logic                  acc;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic                  deq_r, deq_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;

  pmcq_ctrl #(
    .DEPTH      (DEPTH),
    .MAX_QUEUES (MAX_QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_count (cfg_data),
    .acc       (acc),
    .item      (in_data),
    .ctrl      (ctrl),
    .addr      (addr),
    .wdata     (wdata)
  );

  pmcq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (addr),
    .wdata (wdata),
    .re    (ctrl.re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    deq_nxt       = deq_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ctrl.status;
      deq_nxt       = ctrl.re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    deq_r    <= deq_nxt;
  end

  assign rdata_ext         = 64'(rdata);
  assign out_valid         = out_valid_r;
  assign out_data.status   = status_r;
  assign out_data.data_out = deq_r ? $signed(rdata_ext[WORD_W-1:0]) : '0;

  `PMCQ_ASSERT_NXT(a_accept_gives_result, acc, out_valid,
    "transfer did not produce a result")
  `PMCQ_ASSERT_IMP(a_fail_zero_data, out_valid && out_data.status != ST_OK,
    out_data.data_out == '0, "failed operation returned nonzero data")
  `PMCQ_ASSERT_NXT(a_stall_holds, out_valid && !out_ready,
    out_valid && $stable(status_r) && $stable(deq_r),
    "stalled result changed")

endmodule

// File: rtl/pmcq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pmcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pmcq_ctrl.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue pointer control
// Holds the queue count, partition size and per-queue pointers; decodes one
// operation per cycle into a status and a storage access.
// ----------------------------------------------------------------------------
`include "partitioned_multi_circular_queue_macros.svh"

module pmcq_ctrl #(
  parameter int DEPTH      = pmcq_pkg::DEPTH_DEF,
  parameter int MAX_QUEUES = pmcq_pkg::MAX_QUEUES_DEF,
  parameter int DATA_WIDTH = pmcq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmcq_pkg::COUNT_W-1:0]     cfg_count,
  input  logic                             acc,
  input  pmcq_pkg::in_item_t               item,
  output pmcq_pkg::ctrl_t                  ctrl,
  output logic [$clog2(DEPTH)-1:0]         addr,
  output logic [DATA_WIDTH-1:0]            wdata
);
  import pmcq_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int SW   = PW + 1;
  localparam int MAXN = (MAX_QUEUES < DEPTH) ? MAX_QUEUES : DEPTH;

  logic [SW-1:0] size_tab [MAXN];

  for (genvar g = 0; g < MAXN; g++) begin : g_size
    localparam int PART = DEPTH / (g + 1);
    assign size_tab[g] = SW'(PART);
  end

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SW-1:0]      size_r, size_nxt;
  logic [PW-1:0]      front_r [MAX_QUEUES];
  logic [PW-1:0]      front_nxt [MAX_QUEUES];
  logic [PW-1:0]      rear_r [MAX_QUEUES];
  logic [PW-1:0]      rear_nxt [MAX_QUEUES];
  logic [MAX_QUEUES-1:0] empty_r, empty_nxt;

  logic [PW-1:0]      front_s, rear_s, base, endp, front_adv, rear_adv;
  logic               empty_s, bad_sel;
  logic [PW+SEL_W:0]  base_full;
  logic [SW-1:0]      end_sum;
  logic [63:0]        word_ext;

  // config decode: clamp count and look up partition size
  always_comb begin
    count_nxt = count_r;
    size_nxt  = size_r;
    if (cfg_we) begin
      if (cfg_count == '0) begin
        count_nxt = COUNT_W'(1);
      end else if (int'(cfg_count) > MAXN) begin
        count_nxt = COUNT_W'(MAXN);
      end else begin
        count_nxt = cfg_count;
      end
      for (int k = 0; k < MAXN; k++) begin
        if (int'(count_nxt) == k + 1) begin
          size_nxt = size_tab[k];
        end
      end
    end
  end

  // selected queue and partition bounds
  always_comb begin
    front_s = '0;
    rear_s  = '0;
    empty_s = 1'b1;
    for (int k = 0; k < MAX_QUEUES; k++) begin
      if (int'(item.queue_select) == k) begin
        front_s = front_r[k];
        rear_s  = rear_r[k];
        empty_s = empty_r[k];
      end
    end
    bad_sel   = {1'b0, item.queue_select} >= count_r;
    base_full = (PW+SEL_W+1)'(size_r) * (PW+SEL_W+1)'(item.queue_select);
    base      = base_full[PW-1:0];
    end_sum   = SW'(base) + size_r - SW'(1);
    if ({1'b0, item.queue_select} == count_r - COUNT_W'(1)) begin
      endp = PW'(DEPTH - 1);
    end else begin
      endp = end_sum[PW-1:0];
    end
    rear_adv  = (rear_s >= endp) ? base : rear_s + PW'(1);
    front_adv = (front_s >= endp) ? base : front_s + PW'(1);
  end

  // operation decode and pointer update
  always_comb begin
    ctrl.we     = 1'b0;
    ctrl.re     = 1'b0;
    ctrl.status = ST_OK;
    addr        = front_s;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    empty_nxt   = empty_r;
    if (bad_sel) begin
      ctrl.status = ST_BAD_SEL;
    end else if (item.operation == OP_ENQ) begin
      if (empty_s) begin
        addr    = base;
        ctrl.we = acc;
      end else if (rear_adv == front_s) begin
        ctrl.status = ST_FULL;
      end else begin
        addr    = rear_adv;
        ctrl.we = acc;
      end
    end else begin
      if (empty_s) begin
        ctrl.status = ST_EMPTY;
      end else begin
        ctrl.re = acc;
      end
    end
    for (int k = 0; k < MAX_QUEUES; k++) begin
      if (int'(item.queue_select) == k) begin
        if (ctrl.we) begin
          if (empty_s) begin
            front_nxt[k] = base;
            empty_nxt[k] = 1'b0;
          end
          rear_nxt[k] = addr;
        end
        if (ctrl.re) begin
          if (front_s == rear_s) begin
            front_nxt[k] = base;
            rear_nxt[k]  = base;
            empty_nxt[k] = 1'b1;
          end else begin
            front_nxt[k] = front_adv;
          end
        end
      end
    end
    if (cfg_we) begin
      for (int k = 0; k < MAX_QUEUES; k++) begin
        front_nxt[k] = '0;
        rear_nxt[k]  = '0;
      end
      empty_nxt = '1;
    end
  end

  assign word_ext = 64'($unsigned(item.data_in));
  assign wdata    = word_ext[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
      size_r  <= SW'(DEPTH);
      empty_r <= '1;
      for (int k = 0; k < MAX_QUEUES; k++) begin
        front_r[k] <= '0;
        rear_r[k]  <= '0;
      end
    end else begin
      count_r <= count_nxt;
      size_r  <= size_nxt;
      empty_r <= empty_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  `PMCQ_ASSERT_IMP(a_empty_ptrs_equal, empty_r[0], front_r[0] == rear_r[0],
    "empty queue with unequal pointers")
  `PMCQ_ASSERT_IMP(a_single_access, 1'b1, !(ctrl.we && ctrl.re),
    "storage read and write issued together")
  `PMCQ_ASSERT_IMP(a_access_ok_only, ctrl.we || ctrl.re, ctrl.status == ST_OK,
    "storage access on a failed operation")

endmodule

// File: tb/pmcq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Partitioned multi-queue checker
// Watches the operation, result and queue-count channels. Keeps its own copy
// of the shared storage and the per-queue pointers, predicts the status and
// dequeued word of every accepted operation, and compares each result
// transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module pmcq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pmcq_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pmcq_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pmcq_pkg::COUNT_W-1:0]  cfg_data,
  output int                            pending,
  output int                            errors
);
  import pmcq_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int QMAX  = MAX_QUEUES_DEF;

  logic [WORD_W-1:0]  words [SLOTS];
  int unsigned        head_ptr [QMAX];
  int unsigned        tail_ptr [QMAX];
  bit                 is_empty [QMAX];
  logic [COUNT_W-1:0] queue_cnt;
  out_item_t          pending_results [$];
  int                 waiting = 0;
  int                 mismatches = 0;

  assign pending = waiting;
  assign errors  = mismatches;

  function automatic int unsigned active_queues();
    int unsigned n;
    n = queue_cnt;
    if (n == 0) n = 1;
    if (n > QMAX) n = QMAX;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic void flush_queues();
    for (int k = 0; k < QMAX; k++) begin
      head_ptr[k] = 0;
      tail_ptr[k] = 0;
      is_empty[k] = 1'b1;
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t op_item);
    out_item_t   res;
    int unsigned n, sel, part, base, last, nxt;
    n   = active_queues();
    sel = op_item.queue_select;
    res.status   = ST_OK;
    res.data_out = '0;
    if (sel >= n) begin
      res.status = ST_BAD_SEL;
      return res;
    end
    part = SLOTS / n;
    base = part * sel;
    last = (sel == n - 1) ? SLOTS - 1 : base + part - 1;
    if (op_item.operation == OP_ENQ) begin
      if (is_empty[sel]) begin
        head_ptr[sel] = base;
        tail_ptr[sel] = base;
        is_empty[sel] = 1'b0;
        words[base]   = op_item.data_in;
      end else begin
        nxt = (tail_ptr[sel] >= last) ? base : tail_ptr[sel] + 1;
        if (nxt == head_ptr[sel]) begin
          res.status = ST_FULL;
        end else begin
          tail_ptr[sel] = nxt;
          words[nxt]    = op_item.data_in;
        end
      end
    end else begin
      if (is_empty[sel]) begin
        res.status = ST_EMPTY;
      end else begin
        res.data_out = words[head_ptr[sel]];
        if (head_ptr[sel] == tail_ptr[sel]) begin
          head_ptr[sel] = base;
          tail_ptr[sel] = base;
          is_empty[sel] = 1'b1;
        end else begin
          head_ptr[sel] = (head_ptr[sel] >= last) ? base : head_ptr[sel] + 1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      queue_cnt = 1;
      flush_queues();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        queue_cnt = cfg_data;
        flush_queues();
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: status %0d data_out %0d",
                 out_data.status, out_data.data_out);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.data_out !== want.data_out) begin
            $error("data_out: expected %0d, actual %0d", want.data_out,
                   out_data.data_out);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_result(in_data));
      end
    end
    waiting = pending_results.size();
  end

endmodule

// File: tb/tb_partitioned_multi_circular_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Partitioned multi-queue testbench
// Drives enqueue and dequeue operations through several queue-count settings,
// from a short directed sequence (extreme words, full, empty, bad select,
// count saturation, clearing on count write) into random fill, drain and
// mixed bursts, with random idling on both channels and one long result
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_partitioned_multi_circular_queue;
  import pmcq_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;
  int                 pending;
  int                 errors;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_armed = 1'b0;
  bit hold_off_done = 1'b0;
  int hold_left = 0;
  int cur_count = 1;

  always #10 clk = ~clk;

  partitioned_multi_circular_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pmcq_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  // hold off the result channel once for a long stretch
  always @(negedge clk) begin
    if (hold_off_armed && !hold_off_done) begin
      hold_left = 60;
      hold_off_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_op(op_t op, int sel, logic [WORD_W-1:0] word);
    in_item_t op_item;
    op_item.operation    = op;
    op_item.queue_select = sel[SEL_W-1:0];
    op_item.data_in      = word;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op_item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_count(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_count = (value == 0) ? 1 : (value > MAX_QUEUES_DEF) ? MAX_QUEUES_DEF : value;
  endtask

  task automatic run_bursts(int budget);
    int kind, q, cap, len, sel;
    while (budget > 0) begin
      kind = $urandom_range(0, 9);
      q    = $urandom_range(0, cur_count - 1);
      cap  = (q == cur_count - 1) ?
             DEPTH_DEF - (DEPTH_DEF / cur_count) * (cur_count - 1) :
             DEPTH_DEF / cur_count;
      len  = (kind < 7) ? $urandom_range(1, cap + 2) : $urandom_range(4, 30);
      if (len > budget) len = budget;
      budget -= len;
      for (int i = 0; i < len; i++) begin
        if (kind < 4) begin
          send_op(OP_ENQ, q, $urandom());
        end else if (kind < 7) begin
          send_op(OP_DEQ, q, $urandom());
        end else begin
          sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) :
                $urandom_range(0, cur_count - 1);
          send_op($urandom_range(0, 1) ? OP_DEQ : OP_ENQ, sel, $urandom());
        end
      end
    end
  endtask

  initial begin
    int phase_counts [12] = '{1, 8, 3, 5, 2, 9, 7, 4, 6, 15, 0, 8};
    logic [WORD_W-1:0] fill_word;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill one partition past capacity, then empty, bad select,
    // saturated counts and clearing on count write
    write_count(8);
    for (int i = 0; i < 17; i++) begin
      case (i)
        0: fill_word = 32'h7FFF_FFFF;
        1: fill_word = 32'h8000_0000;
        2: fill_word = 32'h0000_0000;
        3: fill_word = 32'hFFFF_FFFF;
        default: fill_word = $urandom();
      endcase
      send_op(OP_ENQ, 3, fill_word);
    end
    send_op(OP_DEQ, 3, 32'h5555_5555);
    send_op(OP_DEQ, 5, 32'hAAAA_AAAA);
    send_op(OP_ENQ, 7, 32'hAAAA_AAAA);
    send_op(OP_DEQ, 7, '0);
    wait_idle();
    write_count(15);
    send_op(OP_DEQ, 3, '0);
    send_op(OP_ENQ, 7, 32'h5555_5555);
    wait_idle();
    write_count(0);
    send_op(OP_ENQ, 1, 32'h1234_5678);
    send_op(OP_ENQ, 0, 32'h8000_0001);
    send_op(OP_DEQ, 0, '0);
    send_op(OP_DEQ, 0, '0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      write_count(phase_counts[p]);
      send_idle_pct  = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 8 : 0;
      recv_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 8 : 0;
      if (p == 4) hold_off_armed = 1'b1;
      run_bursts((phase_counts[p] <= 1) ? 200 : 105);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pmcq_pkg.sv
rtl/pmcq_ram.sv
rtl/pmcq_ctrl.sv
rtl/partitioned_multi_circular_queue.sv
tb/pmcq_checker.sv
tb/tb_partitioned_multi_circular_queue.sv
